// ----- rtl/core/gle_pkg.sv -----
// ----------------------------------------------------------------------------
// Graph Laplacian entry engine package
// Shared widths, function codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package gle_pkg;

   localparam int NodeCount  = 64;
   localparam int NodeWidth  = 6;
   localparam int SlotCount  = NodeCount * NodeCount;
   localparam int SlotWidth  = 2 * NodeWidth;
   localparam int WeightWidth = 16;
   localparam int DegWidth   = 22;
   localparam int ProdWidth  = 2 * DegWidth;
   localparam int RootWidth  = DegWidth;
   localparam int EntryWidth = 23;
   localparam int NumWidth   = WeightWidth + 16;
   localparam int QuotWidth  = NumWidth;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request fields
      logic rd_issue;    // read adjacency and degrees
      logic ld_write;    // write weight and update degree
      logic clr_write;   // clear one adjacency slot and degree
      logic mul_start;   // form the degree product
      logic sqrt_start;  // start the square root
      logic sqrt_step;   // one square-root iteration
      logic div_start;   // start the division
      logic div_step;    // one division iteration
      logic result_load; // compute and hold the result
   } gle_cmd_type;

   typedef struct packed {
      logic clr_done;
   } gle_sts_type;

endpackage

// ----- rtl/core/gle_datapath.sv -----
// ----------------------------------------------------------------------------
// Graph Laplacian entry datapath
// Adjacency memory, degree registers, square-root and division units.
// ----------------------------------------------------------------------------
module gle_datapath
   import gle_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  gle_cmd_type            cmd,
   input  logic [1:0]             req_func,
   input  logic [NodeWidth-1:0]   req_row,
   input  logic [NodeWidth-1:0]   req_col,
   input  logic [WeightWidth-1:0] req_weight,
   input  logic                   mode,
   output gle_sts_type            sts,
   output logic [EntryWidth-1:0]  entry_value,
   output logic                   zero_degree_fault
);

   logic [WeightWidth-1:0] adj_mem [SlotCount];
   logic [DegWidth-1:0]    deg_ff [NodeCount];

   logic [NodeWidth-1:0]   row_ff, col_ff;
   logic [WeightWidth-1:0] win_ff;
   logic [WeightWidth-1:0] wrd_ff;
   logic [DegWidth-1:0]    dr_ff, dc_ff;
   logic [SlotWidth-1:0]   clr_ff;
   logic [ProdWidth-1:0]   prod_ff, rem_ff;
   logic [ProdWidth-1:0]   rootbit_ff;
   logic [ProdWidth-1:0]   root_ff;
   logic [NumWidth-1:0]    num_ff;
   logic [QuotWidth-1:0]   quot_ff;
   logic [ProdWidth:0]     drem_ff;
   logic [5:0]             dcnt_ff;
   logic [EntryWidth-1:0]  entry_ff;
   logic                   fault_ff;

   logic [SlotWidth-1:0] slot;
   assign slot = {row_ff, col_ff};

   // Square root: one bit pair per step; bit set to 2^42 covers 44 bits.
   logic [ProdWidth-1:0] trial;
   assign trial = root_ff + rootbit_ff;

   // Restoring division, one quotient bit per step.
   logic [ProdWidth:0] dshift;
   assign dshift = {drem_ff[ProdWidth-1:0], num_ff[NumWidth-1]};

   logic                 diag;
   logic [QuotWidth-1:0] qsat;
   logic signed [DegWidth+1:0] comb;
   logic signed [25:0]   norm;
   assign diag = (row_ff == col_ff);
   assign qsat = (quot_ff > QuotWidth'(1 << 24)) ? QuotWidth'(1 << 24) : quot_ff;
   assign comb = $signed({2'b00, (diag ? dr_ff : DegWidth'(0))})
               - $signed({8'd0, wrd_ff});
   // The clamped quotient reaches 2^24, so the normalized entry can fall
   // below the output range and is held at its most negative value.
   assign norm = $signed({1'b0, (diag ? 25'd65536 : 25'd0)})
               - $signed({1'b0, qsat[24:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.capture) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
         win_ff <= req_weight;
      end
      if (cmd.rd_issue) begin
         wrd_ff <= adj_mem[slot];
         dr_ff  <= deg_ff[row_ff];
         dc_ff  <= deg_ff[col_ff];
      end
      if (cmd.ld_write) begin
         adj_mem[slot]  <= win_ff;
         deg_ff[row_ff] <= dr_ff - DegWidth'(wrd_ff) + DegWidth'(win_ff);
      end
      if (cmd.clr_write) begin
         adj_mem[clr_ff] <= '0;
         deg_ff[clr_ff[NodeWidth-1:0]] <= '0;
      end
      if (cmd.mul_start) begin
         prod_ff <= dr_ff * dc_ff;
      end
      if (cmd.sqrt_start) begin
         rem_ff     <= prod_ff;
         root_ff    <= '0;
         rootbit_ff <= ProdWidth'(1) << (ProdWidth - 2);
      end
      if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + rootbit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         rootbit_ff <= rootbit_ff >> 2;
      end
      if (cmd.div_start) begin
         num_ff  <= {wrd_ff, 16'd0};
         drem_ff <= '0;
         quot_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (dshift >= {1'b0, root_ff}) begin
            drem_ff <= dshift - {1'b0, root_ff};
            quot_ff <= {quot_ff[QuotWidth-2:0], 1'b1};
         end else begin
            drem_ff <= dshift;
            quot_ff <= {quot_ff[QuotWidth-2:0], 1'b0};
         end
      end
      if (cmd.result_load) begin
         fault_ff <= 1'b0;
         if (!mode) begin
            if (comb > $signed((DegWidth+2)'(4194303)))
               entry_ff <= EntryWidth'(4194303);
            else
               entry_ff <= comb[EntryWidth-1:0];
         end else if (wrd_ff == '0) begin
            entry_ff <= diag ? EntryWidth'(65536) : '0;
         end else if (prod_ff == '0) begin
            entry_ff <= diag ? EntryWidth'(65536) : '0;
            fault_ff <= 1'b1;
         end else if (norm < -26'sd4194304) begin
            entry_ff <= {1'b1, {(EntryWidth-1){1'b0}}};
         end else begin
            entry_ff <= norm[EntryWidth-1:0];
         end
      end
   end

   assign sts.clr_done     = (clr_ff == SlotWidth'(SlotCount - 1));
   assign entry_value      = entry_ff;
   assign zero_degree_fault = fault_ff;

   logic unused;
   assign unused = ^req_func ^ dcnt_ff[0] ^ ^rem_ff[0];
   always_ff @(posedge clock) dcnt_ff <= '0;

endmodule

// ----- rtl/core/gle_controller.sv -----
// ----------------------------------------------------------------------------
// Graph Laplacian entry controller
// Sequences loads, clears and queries and owns both handshakes.
// ----------------------------------------------------------------------------
module gle_controller
   import gle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_func,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        mode,
   input  gle_sts_type sts,
   output gle_cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_LOAD, S_CLEAR, S_MUL, S_SQRT0, S_SQRT,
      S_DIV0, S_DIV, S_RES, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] func_ff, func_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      func_in  = func_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               func_in = req_func;
               unique case (req_func)
                  FUNC_LOAD, FUNC_QUERY: state_in = S_READ;
                  FUNC_CLEAR:            state_in = S_CLEAR;
                  default:               state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            if (func_ff == FUNC_LOAD) state_in = S_LOAD;
            else if (mode)           state_in = S_MUL;
            else                     state_in = S_RES;
         end
         S_LOAD: begin
            cmd.ld_write = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_MUL: begin
            cmd.mul_start = 1'b1;
            state_in = S_SQRT0;
         end
         S_SQRT0: begin
            cmd.sqrt_start = 1'b1;
            cnt_in = 6'd21;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_DIV0;
         end
         S_DIV0: begin
            cmd.div_start = 1'b1;
            cnt_in = 6'(NumWidth - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_RES;
         end
         S_RES: begin
            cmd.result_load = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         func_ff  <= FUNC_NONE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         func_ff  <= func_in;
      end
   end

endmodule

// ----- rtl/core/graph_laplacian_entry_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Graph Laplacian entry engine
// Dense adjacency store with running row degrees; answers Laplacian entries.
// ----------------------------------------------------------------------------
// Usage: req_ carries one transaction per load, query or clear; rsp_ returns
// one transaction per query only. csr_ writes the normalized_mode bit; the user
// must write it only while the block is idle; the block does not enforce it.
// Flow: a load reads, then writes the weight and degree; a combinatorial query
// reads, then registers the result; a normalized query also forms the degree
// product and runs the 22-step square root and the 32-step division that share
// the iterative datapath. A clear accepts the request, then writes one
// adjacency word per cycle through the single memory port.
// After reset a clearing pass runs with req_tready low.
// One item is in flight at a time; while the receiver stalls, the result is
// held in the output register and no new request is taken.
// ----------------------------------------------------------------------------
module graph_laplacian_entry_engine_unit
   import gle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: func[1:0], row_node[7:2], col_node[13:8], edge_weight[29:14]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: entry_value[22:0], zero_degree_fault[23]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   gle_cmd_type cmd;
   gle_sts_type sts;
   logic        mode_ff;
   logic [EntryWidth-1:0] entry;
   logic        fault;

   // The mode register accepts every write.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b1;
      else if (csr_valid) mode_ff <= csr_data;
   end

   gle_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_func(req_tdata[1:0]), .rsp_tvalid, .rsp_tready,
      .mode(mode_ff), .sts, .cmd
   );

   gle_datapath u_dp (
      .clock, .reset, .cmd,
      .req_func(req_tdata[1:0]),
      .req_row(req_tdata[7:2]),
      .req_col(req_tdata[13:8]),
      .req_weight(req_tdata[29:14]),
      .mode(mode_ff), .sts,
      .entry_value(entry), .zero_degree_fault(fault)
   );

   assign rsp_tdata = {fault, entry};

   logic unused;
   assign unused = ^req_tdata[31:30];

endmodule

// ----- rtl/core/gle_checker.sv -----
// ----------------------------------------------------------------------------
// Graph Laplacian entry checker
// Port-level checks of the engine, attached by bind.
// ----------------------------------------------------------------------------
module gle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response waits");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("engine ready right after reset");

endmodule

bind graph_laplacian_entry_engine_unit gle_checker u_gle_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata
);
